### sv/slsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and the 14-segment font for the segment LCD string writer.
// No dependencies.
package slsw_pkg;

  localparam int unsigned NumPositions = 6;
  localparam int unsigned MarkLimit    = 4;

  localparam logic [15:0] PointBit = 16'h0002;
  localparam logic [15:0] ColonBit = 16'h0020;

  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_POINT,
    MARK_COLON
  } mark_t;

  // One pending emission handed from the hold stage to the encoder.
  typedef struct packed {
    logic [2:0] pos;
    logic [7:0] ch;
    mark_t      mark;
  } emit_t;

  localparam logic [15:0] LetterFont [26] = '{
    16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
    16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
    16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
    16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
  };

  localparam logic [15:0] DigitFont [10] = '{
    16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00, 16'hAF00, 16'hBF00,
    16'h4600, 16'hFF00, 16'hEF00
  };

  function automatic logic [15:0] font_code(input logic [7:0] c);
    logic [7:0]  up;
    logic [15:0] code;
    begin
      up = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
      case (c)
        8'h20:   code = 16'h0000;
        8'h2A:   code = 16'hA0DD;
        8'h28:   code = 16'h0028;
        8'h29:   code = 16'h0011;
        8'h64:   code = 16'hF300;
        8'h6D:   code = 16'hB210;
        8'h6E:   code = 16'h2210;
        8'hB5:   code = 16'h6084;
        8'h2D:   code = 16'hA000;
        8'h2B:   code = 16'hA014;
        8'h2F:   code = 16'h00C0;
        8'hB0:   code = 16'hEC00;
        8'h25:   code = 16'hB300;
        8'hFF:   code = 16'hFFDD;
        default: begin
          if (c >= 8'h30 && c <= 8'h39)
            code = DigitFont[4'(c - 8'h30)];
          else if (up >= 8'h41 && up <= 8'h5A)
            code = LetterFont[5'(up - 8'h41)];
          else
            code = 16'h0000;
        end
      endcase
      font_code = code;
    end
  endfunction

endpackage

### sv/segment_lcd_string_writer.sv
`timescale 1ns / 1ps
// Segment LCD string writer: 14-segment codes and COM bit masks per character.
// Results pass the hold stage register, then the output register. Throughput:
// one input transaction per cycle unless in_stall; the hold stage and the
// output register are the two pipeline stages. Synchronous reset clears the
// held character, digit position, hold flag and both pipeline valid flags.
module segment_lcd_string_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  digit_position,
  output logic [15:0] segment_code,
  output logic [63:0] com0_bits,
  output logic [63:0] com1_bits,
  output logic [63:0] com2_bits,
  output logic [63:0] com3_bits,
  output logic [63:0] clear_mask
);
  import slsw_pkg::*;

  logic        out_ready;
  logic        advance;
  logic        accept;
  logic        req_valid;
  emit_t       req;
  logic [15:0] enc_code;
  logic [63:0] enc_com0;
  logic [63:0] enc_com1;
  logic [63:0] enc_com2;
  logic [63:0] enc_com3;
  logic [63:0] enc_clear;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = !req_valid || out_ready;
  assign in_stall  = !advance;
  assign accept    = in_valid && !in_stall;

  slsw_hold u_hold (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .advance      (advance),
    .char_code    (char_code),
    .end_of_string(end_of_string),
    .req_valid    (req_valid),
    .req          (req)
  );

  slsw_encode u_encode (
    .req         (req),
    .segment_code(enc_code),
    .com0_bits   (enc_com0),
    .com1_bits   (enc_com1),
    .com2_bits   (enc_com2),
    .com3_bits   (enc_com3),
    .clear_mask  (enc_clear)
  );

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (out_ready)
      out_valid <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (out_ready && req_valid) begin
      digit_position <= req.pos;
      segment_code   <= enc_code;
      com0_bits      <= enc_com0;
      com1_bits      <= enc_com1;
      com2_bits      <= enc_com2;
      com3_bits      <= enc_com3;
      clear_mask     <= enc_clear;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(clear_mask) == 4)
    else $error("digit does not own exactly four RAM bits");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((com0_bits | com1_bits | com2_bits | com3_bits) & ~clear_mask) == 64'd0)
    else $error("segment bits fall outside the digit's RAM bits");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_position < 3'(NumPositions))
    else $error("result written for a position that shows nothing");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_ready |-> in_stall)
    else $error("input taken while hold stage is blocked");

endmodule

### sv/slsw_hold.sv
`timescale 1ns / 1ps
// Hold stage: keeps one pending character and the digit position, decides
// when a character is emitted and with which mark. Depends on slsw_pkg.
module slsw_hold (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          advance,
  input  logic [7:0]    char_code,
  input  logic          end_of_string,
  output logic          req_valid,
  output slsw_pkg::emit_t req
);
  import slsw_pkg::*;

  logic [7:0] held_char;
  logic       held_valid;
  logic [2:0] next_position;

  logic [7:0] held_char_next;
  logic       held_valid_next;
  logic [2:0] next_position_next;
  logic       emit;
  mark_t      mark;
  logic [2:0] pos_inc;
  logic       is_dot;
  logic       is_colon;

  always_comb begin
    is_dot   = (char_code == 8'h2E);
    is_colon = (char_code == 8'h3A);
    pos_inc  = (next_position < 3'(NumPositions)) ? (next_position + 3'd1) : next_position;

    held_char_next     = held_char;
    held_valid_next    = held_valid;
    next_position_next = next_position;
    emit               = 1'b0;
    mark               = MARK_NONE;

    if (accept) begin
      if (end_of_string) begin
        emit               = held_valid;
        held_char_next     = 8'h00;
        held_valid_next    = 1'b0;
        next_position_next = 3'd0;
      end else if (is_dot || is_colon) begin
        emit            = held_valid;
        mark            = is_dot ? MARK_POINT : MARK_COLON;
        held_valid_next = 1'b0;
        if (held_valid)
          next_position_next = pos_inc;
      end else begin
        emit            = held_valid;
        held_char_next  = char_code;
        held_valid_next = 1'b1;
        if (held_valid)
          next_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char     <= 8'h00;
      held_valid    <= 1'b0;
      next_position <= 3'd0;
      req_valid     <= 1'b0;
    end else begin
      held_char     <= held_char_next;
      held_valid    <= held_valid_next;
      next_position <= next_position_next;
      if (advance)
        req_valid <= emit && (next_position < 3'(NumPositions));
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (advance) begin
      req.pos  <= next_position;
      req.ch   <= held_char;
      req.mark <= mark;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    next_position <= 3'(NumPositions))
    else $error("digit position ran past saturation");

  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> next_position == 3'd0 && !held_valid)
    else $error("end marker did not restart the string");

  assert property (@(posedge clk) disable iff (rst)
    req_valid |-> req.pos < 3'(NumPositions))
    else $error("emission queued for a position that shows nothing");

endmodule

### sv/slsw_encode.sv
`timescale 1ns / 1ps
// Encoder: font lookup, point/colon merge and scatter of the code nibbles
// onto the display-RAM bits of the digit. Depends on slsw_pkg.
module slsw_encode (
  input  slsw_pkg::emit_t req,
  output logic [15:0]     segment_code,
  output logic [63:0]     com0_bits,
  output logic [63:0]     com1_bits,
  output logic [63:0]     com2_bits,
  output logic [63:0]     com3_bits,
  output logic [63:0]     clear_mask
);
  import slsw_pkg::*;

  // RAM bit for nibble bits 0..3 at each position.
  localparam logic [5:0] PosBits [6][4] = '{
    '{6'd4,  6'd23, 6'd22, 6'd3},
    '{6'd6,  6'd13, 6'd12, 6'd5},
    '{6'd15, 6'd29, 6'd28, 6'd14},
    '{6'd31, 6'd33, 6'd32, 6'd30},
    '{6'd35, 6'd25, 6'd24, 6'd34},
    '{6'd17, 6'd8,  6'd9,  6'd26}
  };

  logic [15:0] code;
  logic [63:0] lane [4];
  logic [63:0] com  [4];
  logic [2:0]  pos;

  always_comb begin
    // Positions above the table reach here only without a valid request; fold them onto the last row.
    pos  = (req.pos < 3'(NumPositions)) ? req.pos : 3'(NumPositions - 1);
    code = font_code(req.ch);
    if (req.pos < 3'(MarkLimit)) begin
      case (req.mark)
        MARK_POINT: code = code | PointBit;
        MARK_COLON: code = code | ColonBit;
        default:    code = code;
      endcase
    end

    for (int b = 0; b < 4; b++)
      lane[b] = 64'd1 << PosBits[pos][b];

    // High nibble goes to COM0, low nibble to COM3.
    for (int c = 0; c < 4; c++) begin
      com[c] = 64'd0;
      for (int b = 0; b < 4; b++)
        if (code[12 - 4 * c + b])
          com[c] = com[c] | lane[b];
    end
  end

  assign segment_code = code;
  assign com0_bits    = com[0];
  assign com1_bits    = com[1];
  assign com2_bits    = com[2];
  assign com3_bits    = com[3];
  assign clear_mask   = lane[0] | lane[1] | lane[2] | lane[3];

endmodule
